@@ design/clu_pkg.sv @@
`timescale 1ns / 1ps
package clu_pkg;

    localparam int OPW = 32;
    localparam int RESW = 32;
    localparam int W = 48;
    localparam int SCHED_LEN = 33;
    localparam int NUM_STAGES = SCHED_LEN + 3;
    localparam int AUXW = 5;
    localparam int ADJ_BIT = 7;
    localparam int LOG_LEAD_BIT = 38;
    localparam int LOG_EXP_SHIFT = 35;
    localparam int LOG_SAT_BIT = 39;

    localparam logic ACT_LOG = 1'b0;
    localparam logic ACT_EXP = 1'b1;

    localparam logic signed [W-1:0] EXP_X0 = 48'sh007F42E61C5A;
    localparam logic signed [W-1:0] LOG_RND = 48'sh80;
    localparam logic signed [W-1:0] LOG_MASK = ~48'sh7F;
    localparam logic signed [W-1:0] EXP_RND = 48'sh40;

    localparam logic [7:0] SCHED [SCHED_LEN] = '{
        8'h01, 8'h82, 8'h83, 8'h84, 8'h04, 8'h05, 8'h06,
        8'h87, 8'h88, 8'h09, 8'h8A, 8'h0B, 8'h8C,
        8'h0D, 8'h0D, 8'h8E, 8'h0F, 8'h90, 8'h11, 8'h12, 8'h93,
        8'h94, 8'h15, 8'h96, 8'h97, 8'h98,
        8'h99, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h9E, 8'h1F
    };

    localparam logic signed [W-1:0] ANGLE [31] = '{
        48'sh0032B803473F, 48'sh00179538DEA7, 48'sh000B9A2C912F, 48'sh0005C73F7233,
        48'sh0002E2E683F7, 48'sh0001715C285F, 48'sh0000B8AB3164, 48'sh00005C553C5C,
        48'sh00002E2A92A3, 48'sh0000171547E0, 48'sh00000B8AA3C2, 48'sh000005C551DB,
        48'sh000002E2A8ED, 48'sh000001715476, 48'sh000000B8AA3B, 48'sh0000005C551E,
        48'sh0000002E2A8F, 48'sh000000171547, 48'sh0000000B8AA4, 48'sh00000005C552,
        48'sh00000002E2A9, 48'sh000000017154, 48'sh00000000B8AA, 48'sh000000005C55,
        48'sh000000002E2B, 48'sh000000001715, 48'sh000000000B8B, 48'sh0000000005C5,
        48'sh0000000002E3, 48'sh000000000171, 48'sh0000000000B9
    };

endpackage

@@ design/clu_req_if.sv @@
`timescale 1ns / 1ps
interface clu_req_if;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [clu_pkg::OPW-1:0]  operand;

    modport source (output valid, output action, output operand, input ready);
    modport sink (input valid, input action, input operand, output ready);
endinterface

@@ design/clu_rsp_if.sv @@
`timescale 1ns / 1ps
interface clu_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [clu_pkg::RESW-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

@@ design/cordic_log2_exp2_unit_top.sv @@
`timescale 1ns / 1ps
// channel | role  | payload
// req     | sink  | action, operand
// rsp     | source| result
//
// One request per cycle unless back-pressure from rsp fills the pipeline; stages are
// normalise, 33 micro-rotations, and two post stages including the output register.
// Throughput is set by the fully unrolled rotation pipeline.
// rst_n clears the valid bits only; payload registers are not reset.
// Each stage holds while its successor is full and stalled; bubbles collapse.
module cordic_log2_exp2_unit_top (
    input  logic      clk,
    input  logic      rst_n,
    clu_req_if.sink   req,
    clu_rsp_if.source rsp
);

    localparam int CS = clu_pkg::SCHED_LEN;
    localparam int NST = clu_pkg::NUM_STAGES;
    localparam int W = clu_pkg::W;
    localparam int AW = clu_pkg::AUXW;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST:0]   rdy;

    logic                  act_reg [CS+1];
    logic [AW-1:0]         aux_reg [CS+1];
    logic signed [W-1:0]   x_reg [CS+1];
    logic signed [W-1:0]   y_reg [CS+1];
    logic signed [W-1:0]   z_reg [CS+1];

    logic                  pact_reg;
    logic [clu_pkg::RESW-1:0] lres_reg;
    logic signed [W-1:0]   xs_reg;
    logic signed [W-1:0]   ys_reg;
    logic [clu_pkg::RESW-1:0] res_reg;

    function automatic logic [AW-1:0] lzc(input logic [clu_pkg::OPW-1:0] d);
        logic [AW-1:0] n;
        n = AW'(clu_pkg::OPW - 1);
        for (int i = 0; i < clu_pkg::OPW; i++)
        begin
            if (d[i])
            begin
                n = AW'(clu_pkg::OPW - 1 - i);
            end
        end
        return n;
    endfunction

    // handshake chain
    always_comb
    begin
        rdy[NST] = rsp.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? req.valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req.ready = rdy[0];
    assign rsp.valid = v_reg[NST-1];
    assign rsp.result = res_reg;

    // normalise / seed
    logic [AW-1:0]           lz;
    logic [clu_pkg::OPW-1:0] norm;
    logic [AW-1:0]           aux_next;
    logic signed [W-1:0]     x0_next;
    logic signed [W-1:0]     y0_next;
    logic signed [W-1:0]     z0_next;

    always_comb
    begin
        lz = lzc(req.operand);
        norm = req.operand << lz;
        if (req.action == clu_pkg::ACT_EXP)
        begin
            aux_next = ~req.operand[31:27];
            x0_next = clu_pkg::EXP_X0;
            y0_next = '0;
            z0_next = W'({req.operand[26:0], 11'b0});
        end
        else
        begin
            aux_next = lz;
            y0_next = W'({norm[30:0], 6'b0});
            x0_next = y0_next | (W'(1) << clu_pkg::LOG_LEAD_BIT);
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            act_reg[0] <= req.action;
            aux_reg[0] <= aux_next;
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
        end
    end

    // micro-rotations
    for (genvar j = 1; j <= CS; j++)
    begin : g_rot
        localparam int N = int'(clu_pkg::SCHED[j-1][4:0]);
        localparam bit ADJ = clu_pkg::SCHED[j-1][clu_pkg::ADJ_BIT];

        logic signed [W-1:0] xa;
        logic signed [W-1:0] ya;
        logic signed [W-1:0] x_next;
        logic signed [W-1:0] y_next;
        logic signed [W-1:0] z_next;
        logic                neg;

        always_comb
        begin
            xa = x_reg[j-1];
            ya = y_reg[j-1];
            if (ADJ)
            begin
                xa = x_reg[j-1] - (x_reg[j-1] >>> N);
                ya = y_reg[j-1] - (y_reg[j-1] >>> N);
            end
            neg = (act_reg[j-1] == clu_pkg::ACT_EXP) ? !z_reg[j-1][W-1] : ya[W-1];
            if (neg)
            begin
                x_next = xa + (ya >>> N);
                y_next = ya + (xa >>> N);
                z_next = z_reg[j-1] - clu_pkg::ANGLE[N-1];
            end
            else
            begin
                x_next = xa - (ya >>> N);
                y_next = ya - (xa >>> N);
                z_next = z_reg[j-1] + clu_pkg::ANGLE[N-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                act_reg[j] <= act_reg[j-1];
                aux_reg[j] <= aux_reg[j-1];
                x_reg[j] <= x_next;
                y_reg[j] <= y_next;
                z_reg[j] <= z_next;
            end
        end
    end

    // post: log merge and round, exp shifts
    logic signed [W-1:0] t;

    always_comb
    begin
        t = ((z_reg[CS] >>> 2) & clu_pkg::LOG_MASK) + clu_pkg::LOG_RND
            + (W'(aux_reg[CS] ^ AW'(31)) << clu_pkg::LOG_EXP_SHIFT);
        if (aux_reg[CS] == '0 && !t[clu_pkg::LOG_SAT_BIT])
        begin
            t = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[CS+1])
        begin
            pact_reg <= act_reg[CS];
            lres_reg <= t[39:8];
            xs_reg <= x_reg[CS] >>> aux_reg[CS];
            ys_reg <= y_reg[CS] >>> aux_reg[CS];
        end
    end

    logic signed [W-1:0] s;

    assign s = xs_reg + ys_reg + clu_pkg::EXP_RND;

    always_ff @(posedge clk)
    begin
        if (rdy[CS+2])
        begin
            res_reg <= (pact_reg == clu_pkg::ACT_EXP) ? s[38:7] : lres_reg;
        end
    end

`ifndef SYNTHESIS
    a_headroom: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[CS] |-> (x_reg[CS][W-1] == x_reg[CS][W-2])
                   && (y_reg[CS][W-1] == y_reg[CS][W-2]))
        else $error("rotation datapath out of headroom");

    a_post_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[CS+1] && !rdy[CS+1] |=> v_reg[CS+1] && $stable(lres_reg)
                                      && $stable(xs_reg) && $stable(ys_reg))
        else $error("post stage lost data under stall");

    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NST-1] |-> req.ready)
        else $error("request refused with empty output stage");
`endif

endmodule
